/* rtl/core/ray_sphere_lambert_shade_assert.svh */
// ----------------------------------------------------------------------------
// ray_sphere_lambert_shade assertion macros
// Shorthand for clocked properties sampled on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RAY_SPHERE_LAMBERT_SHADE_ASSERT_SVH
`define RAY_SPHERE_LAMBERT_SHADE_ASSERT_SVH

// condition holds at every sampled edge
`define RSL_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent, overlapping
`define RSL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/core/rsl_pkg.sv */
// ----------------------------------------------------------------------------
// rsl_pkg
// Widths, register map, reset values and shared types of the sphere shader.
// ----------------------------------------------------------------------------
package rsl_pkg;

  localparam int DataWidth    = 16;
  localparam int FracBits     = 12;
  localparam int OutWidth     = DataWidth - 1;
  localparam int AddrWidth    = 5;
  localparam int BusWidth     = 32;
  localparam int AWidth       = 22;   // a, h, c
  localparam int DivisorWidth = 20;   // a is non-negative and below 2^20
  localparam int RadWidth     = 42;   // disc << FracBits
  localparam int RootWidth    = RadWidth / 2;
  localparam int DvdWidth     = 34;   // |num| << FracBits
  localparam int TWidth       = 32;

  localparam logic [2:0] RegEyeX   = 3'd0;
  localparam logic [2:0] RegEyeY   = 3'd1;
  localparam logic [2:0] RegEyeZ   = 3'd2;
  localparam logic [2:0] RegRadius = 3'd3;
  localparam logic [2:0] RegLightX = 3'd4;
  localparam logic [2:0] RegLightY = 3'd5;
  localparam logic [2:0] RegLightZ = 3'd6;

  typedef struct packed {
    logic signed [DataWidth-1:0] eye_x;
    logic signed [DataWidth-1:0] eye_y;
    logic signed [DataWidth-1:0] eye_z;
    logic        [OutWidth-1:0]  sphere_radius;
    logic signed [DataWidth-1:0] light_x;
    logic signed [DataWidth-1:0] light_y;
    logic signed [DataWidth-1:0] light_z;
  } rsl_cfg_t;

  localparam rsl_cfg_t CfgReset = '{
    eye_x: 16'sd0, eye_y: 16'sd0, eye_z: 16'sd8192, sphere_radius: 15'd4096,
    light_x: 16'sd2365, light_y: 16'sd2365, light_z: 16'sd2365
  };

  // per-pixel sideband that rides along the pipe
  typedef struct packed {
    logic                        nohit;
    logic signed [DataWidth-1:0] dx;
    logic signed [DataWidth-1:0] dy;
    logic signed [DataWidth:0]   dz;
  } rsl_ctx_t;

  // clamp to +-(2^31 - 1)
  function automatic logic signed [TWidth-1:0] sat_t(input logic signed [39:0] v);
    logic signed [TWidth-1:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -40'sd2147483647) begin
      r = -32'sd2147483647;
    end else begin
      r = v[TWidth-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/rsl_quad.sv */
// ----------------------------------------------------------------------------
// rsl_quad
// Front end: quadratic coefficients a, h, c and the discriminant.
// ----------------------------------------------------------------------------
module rsl_quad (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic signed [rsl_pkg::DataWidth-1:0]  in_ray_x,
  input  logic signed [rsl_pkg::DataWidth-1:0]  in_ray_y,
  input  rsl_pkg::rsl_cfg_t                     cfg,
  output logic                                  out_valid,
  output rsl_pkg::rsl_ctx_t                     out_ctx,
  output logic signed [rsl_pkg::AWidth-1:0]     out_h,
  output logic [rsl_pkg::DivisorWidth-1:0]      out_a,
  output logic [rsl_pkg::RadWidth-1:0]          out_rad
);
  import rsl_pkg::*;

  // stage 0: capture the beat
  logic                        v0_r;
  logic signed [15:0]          dx0_r, dy0_r;
  logic signed [16:0]          dz0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    dx0_r <= in_ray_x;
    dy0_r <= in_ray_y;
    dz0_r <= -(17'(cfg.eye_z));
  end

  // stage A: products
  logic signed [31:0] pxx, pyy, pxe, pye, pex, pey, pez;
  logic signed [33:0] pzz;
  logic signed [32:0] pze;
  logic        [29:0] prr;

  assign pxx = 32'(dx0_r) * 32'(dx0_r);
  assign pyy = 32'(dy0_r) * 32'(dy0_r);
  assign pzz = 34'(dz0_r) * 34'(dz0_r);
  assign pxe = 32'(dx0_r) * 32'(cfg.eye_x);
  assign pye = 32'(dy0_r) * 32'(cfg.eye_y);
  assign pze = 33'(dz0_r) * 33'(cfg.eye_z);
  assign pex = 32'(cfg.eye_x) * 32'(cfg.eye_x);
  assign pey = 32'(cfg.eye_y) * 32'(cfg.eye_y);
  assign pez = 32'(cfg.eye_z) * 32'(cfg.eye_z);
  assign prr = 30'(cfg.sphere_radius) * 30'(cfg.sphere_radius);

  logic               va_r;
  logic signed [15:0] dxa_r, dya_r;
  logic signed [16:0] dza_r;
  logic signed [19:0] qxx_r, qyy_r, qxe_r, qye_r, qex_r, qey_r, qez_r;
  logic signed [21:0] qzz_r;
  logic signed [20:0] qze_r;
  logic        [17:0] qrr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= v0_r;
    end
  end

  // upper bits of a product are the floor shift
  always_ff @(posedge clk) begin
    dxa_r <= dx0_r;
    dya_r <= dy0_r;
    dza_r <= dz0_r;
    qxx_r <= pxx[31:12];
    qyy_r <= pyy[31:12];
    qzz_r <= pzz[33:12];
    qxe_r <= pxe[31:12];
    qye_r <= pye[31:12];
    qze_r <= pze[32:12];
    qex_r <= pex[31:12];
    qey_r <= pey[31:12];
    qez_r <= pez[31:12];
    qrr_r <= prr[29:12];
  end

  // stage B: sums
  logic signed [23:0] a_nxt, h_nxt, c_nxt;

  assign a_nxt = 24'(qxx_r) + 24'(qyy_r) + 24'(qzz_r);
  assign h_nxt = 24'(qxe_r) + 24'(qye_r) + 24'(qze_r);
  assign c_nxt = 24'(qex_r) + 24'(qey_r) + 24'(qez_r) - 24'(signed'({1'b0, qrr_r}));

  logic                      vb_r;
  logic signed [15:0]        dxb_r, dyb_r;
  logic signed [16:0]        dzb_r;
  logic signed [AWidth-1:0]  ab_r, hb_r, cb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    dxb_r <= dxa_r;
    dyb_r <= dya_r;
    dzb_r <= dza_r;
    ab_r  <= a_nxt[AWidth-1:0];
    hb_r  <= h_nxt[AWidth-1:0];
    cb_r  <= c_nxt[AWidth-1:0];
  end

  // stage C: h*h and a*c
  logic signed [43:0] phh, pac;

  assign phh = 44'(hb_r) * 44'(hb_r);
  assign pac = 44'(ab_r) * 44'(cb_r);

  logic                     vc_r;
  logic signed [15:0]       dxc_r, dyc_r;
  logic signed [16:0]       dzc_r;
  logic signed [AWidth-1:0] ac_r, hc_r;
  logic signed [31:0]       hh_r, acp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    dxc_r <= dxb_r;
    dyc_r <= dyb_r;
    dzc_r <= dzb_r;
    ac_r  <= ab_r;
    hc_r  <= hb_r;
    hh_r  <= phh[43:12];
    acp_r <= pac[43:12];
  end

  // stage D: discriminant and miss test
  logic signed [32:0] disc;
  logic               nohit;

  assign disc  = 33'(hh_r) - 33'(acp_r);
  assign nohit = disc[32] || (ac_r == '0);

  logic                     vd_r;
  rsl_ctx_t                 ctxd_r;
  logic signed [AWidth-1:0] hd_r;
  logic [DivisorWidth-1:0]  ad_r;
  logic [RadWidth-1:0]      radd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else begin
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    ctxd_r.nohit <= nohit;
    ctxd_r.dx    <= dxc_r;
    ctxd_r.dy    <= dyc_r;
    ctxd_r.dz    <= dzc_r;
    hd_r         <= hc_r;
    ad_r         <= ac_r[DivisorWidth-1:0];
    radd_r       <= nohit ? '0 : {disc[RadWidth-FracBits-1:0], {FracBits{1'b0}}};
  end

  assign out_valid = vd_r;
  assign out_ctx   = ctxd_r;
  assign out_h     = hd_r;
  assign out_a     = ad_r;
  assign out_rad   = radd_r;

endmodule

/* rtl/core/rsl_sqrt.sv */
// ----------------------------------------------------------------------------
// rsl_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rsl_sqrt (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  rsl_pkg::rsl_ctx_t                     in_ctx,
  input  logic signed [rsl_pkg::AWidth-1:0]     in_h,
  input  logic [rsl_pkg::DivisorWidth-1:0]      in_a,
  input  logic [rsl_pkg::RadWidth-1:0]          in_rad,
  output logic                                  out_valid,
  output rsl_pkg::rsl_ctx_t                     out_ctx,
  output logic signed [rsl_pkg::AWidth-1:0]     out_h,
  output logic [rsl_pkg::DivisorWidth-1:0]      out_a,
  output logic [rsl_pkg::RootWidth-1:0]         out_root
);
  import rsl_pkg::*;

  logic                     v_w   [0:RootWidth];
  rsl_ctx_t                 ctx_w [0:RootWidth];
  logic signed [AWidth-1:0] h_w   [0:RootWidth];
  logic [DivisorWidth-1:0]  a_w   [0:RootWidth];
  logic [RadWidth-1:0]      n_w   [0:RootWidth];
  logic [RadWidth-1:0]      res_w [0:RootWidth];

  assign v_w[0]   = in_valid;
  assign ctx_w[0] = in_ctx;
  assign h_w[0]   = in_h;
  assign a_w[0]   = in_a;
  assign n_w[0]   = in_rad;
  assign res_w[0] = '0;

  for (genvar k = 0; k < RootWidth; k++) begin : g_stage
    localparam int                Sh      = 2 * (RootWidth - 1 - k);
    localparam logic [RadWidth-1:0] StepBit = RadWidth'(1) << Sh;

    logic                     v_r;
    rsl_ctx_t                 ctx_r;
    logic signed [AWidth-1:0] h_r;
    logic [DivisorWidth-1:0]  a_r;
    logic [RadWidth-1:0]      n_r, res_r;
    logic [RadWidth-1:0]      trial, n_nxt, res_nxt;

    always_comb begin
      trial = res_w[k] + StepBit;
      if (n_w[k] >= trial) begin
        n_nxt   = n_w[k] - trial;
        res_nxt = (res_w[k] >> 1) + StepBit;
      end else begin
        n_nxt   = n_w[k];
        res_nxt = res_w[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else begin
        v_r <= v_w[k];
      end
    end

    always_ff @(posedge clk) begin
      ctx_r <= ctx_w[k];
      h_r   <= h_w[k];
      a_r   <= a_w[k];
      n_r   <= n_nxt;
      res_r <= res_nxt;
    end

    assign v_w[k+1]   = v_r;
    assign ctx_w[k+1] = ctx_r;
    assign h_w[k+1]   = h_r;
    assign a_w[k+1]   = a_r;
    assign n_w[k+1]   = n_r;
    assign res_w[k+1] = res_r;
  end

  assign out_valid = v_w[RootWidth];
  assign out_ctx   = ctx_w[RootWidth];
  assign out_h     = h_w[RootWidth];
  assign out_a     = a_w[RootWidth];
  assign out_root  = res_w[RootWidth][RootWidth-1:0];

endmodule

/* rtl/core/rsl_div.sv */
// ----------------------------------------------------------------------------
// rsl_div
// Forms -h - s and divides its magnitude, shifted up, by a: restoring
// divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rsl_div (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  rsl_pkg::rsl_ctx_t                     in_ctx,
  input  logic signed [rsl_pkg::AWidth-1:0]     in_h,
  input  logic [rsl_pkg::DivisorWidth-1:0]      in_a,
  input  logic [rsl_pkg::RootWidth-1:0]         in_root,
  output logic                                  out_valid,
  output rsl_pkg::rsl_ctx_t                     out_ctx,
  output logic                                  out_neg,
  output logic [rsl_pkg::DvdWidth-1:0]          out_quo
);
  import rsl_pkg::*;

  // prep stage
  logic signed [23:0] num;
  logic [23:0]        mag;

  assign num = -(24'(in_h)) - 24'(signed'({1'b0, in_root}));
  assign mag = num[23] ? 24'(-num) : 24'(num);

  logic                    vp_r, negp_r;
  rsl_ctx_t                ctxp_r;
  logic [DivisorWidth-1:0] ap_r;
  logic [DvdWidth-1:0]     dvdp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
    end else begin
      vp_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    ctxp_r <= in_ctx;
    negp_r <= num[23];
    ap_r   <= in_a;
    dvdp_r <= {mag[DvdWidth-FracBits-1:0], {FracBits{1'b0}}};
  end

  logic                    v_w   [0:DvdWidth];
  rsl_ctx_t                ctx_w [0:DvdWidth];
  logic                    neg_w [0:DvdWidth];
  logic [DivisorWidth-1:0] a_w   [0:DvdWidth];
  logic [DvdWidth-1:0]     dvd_w [0:DvdWidth];
  logic [DivisorWidth-1:0] rem_w [0:DvdWidth];
  logic [DvdWidth-1:0]     q_w   [0:DvdWidth];

  assign v_w[0]   = vp_r;
  assign ctx_w[0] = ctxp_r;
  assign neg_w[0] = negp_r;
  assign a_w[0]   = ap_r;
  assign dvd_w[0] = dvdp_r;
  assign rem_w[0] = '0;
  assign q_w[0]   = '0;

  for (genvar k = 0; k < DvdWidth; k++) begin : g_stage
    logic                    v_r, neg_r;
    rsl_ctx_t                ctx_r;
    logic [DivisorWidth-1:0] a_r, rem_r;
    logic [DvdWidth-1:0]     dvd_r, q_r;
    logic [DivisorWidth:0]   rs, diff;
    logic                    ge;
    logic [DivisorWidth-1:0] rem_nxt;

    assign rs      = {rem_w[k], dvd_w[k][DvdWidth-1-k]};
    assign diff    = rs - {1'b0, a_w[k]};
    assign ge      = (rs >= {1'b0, a_w[k]});
    assign rem_nxt = ge ? diff[DivisorWidth-1:0] : rs[DivisorWidth-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else begin
        v_r <= v_w[k];
      end
    end

    always_ff @(posedge clk) begin
      ctx_r <= ctx_w[k];
      neg_r <= neg_w[k];
      a_r   <= a_w[k];
      dvd_r <= dvd_w[k];
      rem_r <= rem_nxt;
      q_r   <= {q_w[k][DvdWidth-2:0], ge};
    end

    assign v_w[k+1]   = v_r;
    assign ctx_w[k+1] = ctx_r;
    assign neg_w[k+1] = neg_r;
    assign a_w[k+1]   = a_r;
    assign dvd_w[k+1] = dvd_r;
    assign rem_w[k+1] = rem_r;
    assign q_w[k+1]   = q_r;
  end

  assign out_valid = v_w[DvdWidth];
  assign out_ctx   = ctx_w[DvdWidth];
  assign out_neg   = neg_w[DvdWidth];
  assign out_quo   = q_w[DvdWidth];

endmodule

/* rtl/core/rsl_shade.sv */
// ----------------------------------------------------------------------------
// rsl_shade
// Back end: signed root t, hit point, Lambert dot product and output clamp.
// ----------------------------------------------------------------------------
module rsl_shade (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  rsl_pkg::rsl_ctx_t                   in_ctx,
  input  logic                                in_neg,
  input  logic [rsl_pkg::DvdWidth-1:0]        in_quo,
  input  rsl_pkg::rsl_cfg_t                   cfg,
  output logic                                out_valid,
  output logic [rsl_pkg::OutWidth-1:0]        out_intensity,
  output logic                                out_hit
);
  import rsl_pkg::*;

  // stage T: sign and saturate t
  logic signed [DvdWidth:0] qs, tv;

  assign qs = signed'({1'b0, in_quo});
  assign tv = in_neg ? -qs : qs;

  logic                     vt_r;
  rsl_ctx_t                 ctxt_r;
  logic signed [TWidth-1:0] t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vt_r <= 1'b0;
    end else begin
      vt_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    ctxt_r <= in_ctx;
    t_r    <= sat_t(40'(tv));
  end

  // stage M1: t * d
  logic signed [47:0] ptx, pty;
  logic signed [48:0] ptz;

  assign ptx = 48'(t_r) * 48'(ctxt_r.dx);
  assign pty = 48'(t_r) * 48'(ctxt_r.dy);
  assign ptz = 49'(t_r) * 49'(ctxt_r.dz);

  logic               vm1_r, nohit1_r;
  logic signed [35:0] mx_r, my_r;
  logic signed [36:0] mz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm1_r <= 1'b0;
    end else begin
      vm1_r <= vt_r;
    end
  end

  always_ff @(posedge clk) begin
    nohit1_r <= ctxt_r.nohit;
    mx_r     <= ptx[47:12];
    my_r     <= pty[47:12];
    mz_r     <= ptz[48:12];
  end

  // stage M2: hit point
  logic                     vm2_r, nohit2_r;
  logic signed [TWidth-1:0] px_r, py_r, pz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm2_r <= 1'b0;
    end else begin
      vm2_r <= vm1_r;
    end
  end

  always_ff @(posedge clk) begin
    nohit2_r <= nohit1_r;
    px_r     <= sat_t(40'(cfg.eye_x) + 40'(mx_r));
    py_r     <= sat_t(40'(cfg.eye_y) + 40'(my_r));
    pz_r     <= sat_t(40'(cfg.eye_z) + 40'(mz_r));
  end

  // stage M3: light products
  logic signed [47:0] plx, ply, plz;

  assign plx = 48'(cfg.light_x) * 48'(px_r);
  assign ply = 48'(cfg.light_y) * 48'(py_r);
  assign plz = 48'(cfg.light_z) * 48'(pz_r);

  logic               vm3_r, nohit3_r;
  logic signed [35:0] lx_r, ly_r, lz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm3_r <= 1'b0;
    end else begin
      vm3_r <= vm2_r;
    end
  end

  always_ff @(posedge clk) begin
    nohit3_r <= nohit2_r;
    lx_r     <= plx[47:12];
    ly_r     <= ply[47:12];
    lz_r     <= plz[47:12];
  end

  // stage M4: sum, clamp, output register
  localparam logic signed [37:0] OutMax = 38'sd32767;

  logic signed [37:0]    dot;
  logic [OutWidth-1:0]   inten_nxt;

  assign dot = 38'(lx_r) + 38'(ly_r) + 38'(lz_r);

  always_comb begin
    if (nohit3_r || dot[37]) begin
      inten_nxt = '0;
    end else if (dot > OutMax) begin
      inten_nxt = OutMax[OutWidth-1:0];
    end else begin
      inten_nxt = dot[OutWidth-1:0];
    end
  end

  logic                vo_r, hit_r;
  logic [OutWidth-1:0] inten_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= vm3_r;
    end
  end

  always_ff @(posedge clk) begin
    hit_r   <= !nohit3_r;
    inten_r <= inten_nxt;
  end

  assign out_valid     = vo_r;
  assign out_intensity = inten_r;
  assign out_hit       = hit_r;

endmodule

/* rtl/core/ray_sphere_lambert_shade.sv */
// A pixel passes the rsl_quad, rsl_sqrt, rsl_div and rsl_shade register stages in that order.
// Throughput: one pixel per cycle; busy stays low, the pipe never stalls.
// Depth is set by the bit-serial square root (21 stages) and divider (34 stages).
// Synchronous active-low reset clears the valid bits and loads register defaults.
// The receiver cannot stall; results are shown for exactly one cycle.
// ----------------------------------------------------------------------------
// ray_sphere_lambert_shade
// Ray-sphere hit test with Lambert shading, fully pipelined, APB register port.
// ----------------------------------------------------------------------------
module ray_sphere_lambert_shade (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [rsl_pkg::DataWidth-1:0]  in_ray_x,
  input  logic signed [rsl_pkg::DataWidth-1:0]  in_ray_y,
  output logic                                  out_valid,
  output logic [rsl_pkg::OutWidth-1:0]          out_intensity,
  output logic                                  out_hit,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [rsl_pkg::AddrWidth-1:0]         paddr,
  input  logic [rsl_pkg::BusWidth-1:0]          pwdata,
  output logic [rsl_pkg::BusWidth-1:0]          prdata,
  output logic                                  pready
);
  import rsl_pkg::*;

  rsl_cfg_t   cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[AddrWidth-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CfgReset;
    end else if (wr_en) begin
      case (reg_idx)
        RegEyeX:   cfg_r.eye_x         <= pwdata[DataWidth-1:0];
        RegEyeY:   cfg_r.eye_y         <= pwdata[DataWidth-1:0];
        RegEyeZ:   cfg_r.eye_z         <= pwdata[DataWidth-1:0];
        RegRadius: cfg_r.sphere_radius <= pwdata[OutWidth-1:0];
        RegLightX: cfg_r.light_x       <= pwdata[DataWidth-1:0];
        RegLightY: cfg_r.light_y       <= pwdata[DataWidth-1:0];
        RegLightZ: cfg_r.light_z       <= pwdata[DataWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegEyeX:   prdata = BusWidth'(cfg_r.eye_x);
      RegEyeY:   prdata = BusWidth'(cfg_r.eye_y);
      RegEyeZ:   prdata = BusWidth'(cfg_r.eye_z);
      RegRadius: prdata = BusWidth'(cfg_r.sphere_radius);
      RegLightX: prdata = BusWidth'(cfg_r.light_x);
      RegLightY: prdata = BusWidth'(cfg_r.light_y);
      RegLightZ: prdata = BusWidth'(cfg_r.light_z);
      default:   prdata = '0;
    endcase
  end

  logic                     q_valid, s_valid, d_valid;
  rsl_ctx_t                 q_ctx, s_ctx, d_ctx;
  logic signed [AWidth-1:0] q_h, s_h;
  logic [DivisorWidth-1:0]  q_a, s_a;
  logic [RadWidth-1:0]      q_rad;
  logic [RootWidth-1:0]     s_root;
  logic                     d_neg;
  logic [DvdWidth-1:0]      d_quo;

  rsl_quad u_quad (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_ray_x  (in_ray_x),
    .in_ray_y  (in_ray_y),
    .cfg       (cfg_r),
    .out_valid (q_valid),
    .out_ctx   (q_ctx),
    .out_h     (q_h),
    .out_a     (q_a),
    .out_rad   (q_rad)
  );

  rsl_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_valid),
    .in_ctx    (q_ctx),
    .in_h      (q_h),
    .in_a      (q_a),
    .in_rad    (q_rad),
    .out_valid (s_valid),
    .out_ctx   (s_ctx),
    .out_h     (s_h),
    .out_a     (s_a),
    .out_root  (s_root)
  );

  rsl_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s_valid),
    .in_ctx    (s_ctx),
    .in_h      (s_h),
    .in_a      (s_a),
    .in_root   (s_root),
    .out_valid (d_valid),
    .out_ctx   (d_ctx),
    .out_neg   (d_neg),
    .out_quo   (d_quo)
  );

  rsl_shade u_shade (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (d_valid),
    .in_ctx        (d_ctx),
    .in_neg        (d_neg),
    .in_quo        (d_quo),
    .cfg           (cfg_r),
    .out_valid     (out_valid),
    .out_intensity (out_intensity),
    .out_hit       (out_hit)
  );

endmodule

/* rtl/core/rsl_checker.sv */
// ----------------------------------------------------------------------------
// rsl_checker
// Port-level checks of the shader, bound to the top level.
// ----------------------------------------------------------------------------
`include "ray_sphere_lambert_shade_assert.svh"

module rsl_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic                          out_hit,
  input logic [rsl_pkg::OutWidth-1:0]  out_intensity,
  input logic                          pready
);

  `RSL_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised on a non-stalling pipe")
  `RSL_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")
  // every accepted beat comes out after the fixed pipe depth
  `RSL_ASSERT_IMPL(a_fixed_latency, start && !busy, ##66 out_valid, "result beat missing")
  `RSL_ASSERT_IMPL(a_miss_is_dark, out_valid && !out_hit, out_intensity == '0, "lit miss")

endmodule

bind ray_sphere_lambert_shade rsl_checker u_rsl_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_hit       (out_hit),
  .out_intensity (out_intensity),
  .pready        (pready)
);
